### rtl/core/iba_pkg.sv
// Package for the indexed block allocator: payload types, status codes and sizes.
package iba_pkg;

    localparam int DISK_BLOCKS_DEF = 256;
    localparam int DIR_ENTRIES_DEF = 16;
    localparam int MAX_DATA_DEF    = 31;

    localparam logic OP_CREATE = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_DUP      = 3'd1,
        ST_FEW      = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_FULL     = 3'd4,
        ST_BADCNT   = 3'd5
    } t_status;

    typedef struct packed {
        logic        opcode;
        logic [63:0] file_key;
        logic [4:0]  block_count;
    } t_req;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] block_number;
        logic       block_role;
        logic       last;
        logic [8:0] free_blocks;
    } t_rsp;

endpackage

### rtl/core/iba_bitmap.sv
// Free-block bitmap: one-bit synchronous memory with a set/clear port and a read port.
module iba_bitmap #(
    parameter int DISK_BLOCKS = 256
) (
    input  logic                           i_clk,
    input  logic                           i_we,
    input  logic [$clog2(DISK_BLOCKS)-1:0] i_waddr,
    input  logic                           i_wdata,
    input  logic [$clog2(DISK_BLOCKS)-1:0] i_raddr,
    output logic                           o_rdata
);
    logic r_mem [DISK_BLOCKS];

    // registered read; a same-address write returns the old bit
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### rtl/core/iba_blklist.sv
// Block list store: index and data block numbers of each directory slot.
module iba_blklist #(
    parameter int DEPTH = 512,
    parameter int AW    = 9,
    parameter int DW    = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [DEPTH];

    // registered read, one write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### rtl/core/indexed_block_allocator.sv
// Indexed block allocator top level: request sequencer over bitmap and block list memories.
//
// Usage: requests enter on i_req_valid/o_req_ready as t_req transactions (create or
// delete by 64-bit file key). Results leave on o_rsp_valid/i_rsp_ready as t_rsp
// transactions; a create that succeeds returns count+1 results (index block first,
// then data blocks, last set on the final one); every other request returns one.
// One request is handled at a time, and the next is taken only once the last result
// of the previous one has left. The directory (up to DIR_ENTRIES keys) is searched
// one slot per cycle. A create then scans the bitmap from block 0 through the
// registered memory read, skipping busy blocks and claiming free ones, then reads the
// slot's list back, one result per block. A delete walks the slot's list to free
// blocks, then recounts free blocks over all managed blocks. Reset and each i_cfg_we
// write start a clearing pass that marks every block free; requests are not taken
// during it. A stalled receiver holds the result register; the sequencer waits on it.
module indexed_block_allocator
    import iba_pkg::*;
#(
    parameter int DISK_BLOCKS     = DISK_BLOCKS_DEF,
    parameter int DIR_ENTRIES     = DIR_ENTRIES_DEF,
    parameter int MAX_DATA_BLOCKS = MAX_DATA_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [8:0]    i_cfg_wdata,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  iba_pkg::t_req i_req,
    output logic          o_rsp_valid,
    input  logic          i_rsp_ready,
    output iba_pkg::t_rsp o_rsp
);
    localparam int BW  = $clog2(DISK_BLOCKS);
    localparam int CW  = BW + 1;
    localparam int SW  = (DIR_ENTRIES > 1) ? $clog2(DIR_ENTRIES) : 1;
    localparam int LW  = $clog2(MAX_DATA_BLOCKS + 2);
    localparam int LD  = MAX_DATA_BLOCKS + 1;
    localparam int AW  = $clog2(DIR_ENTRIES * LD);
    localparam int LAW = (AW > 0) ? AW : 1;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_FIND, S_CHECK, S_SCAN, S_RD, S_OUT,
        S_DEL_RD, S_DEL_WR, S_CNT, S_RESP
    } t_state;

    t_state            r_state;
    logic [BW-1:0]     r_ptr;
    logic              r_ptr_end;
    logic [8:0]        r_biu;
    logic [CW-1:0]     r_n;
    logic [8:0]        r_free;
    logic [8:0]        r_cnt;
    t_req              r_req;
    logic [SW-1:0]     r_slot;
    logic              r_hit;
    logic [SW-1:0]     r_hit_slot;
    logic              r_empty;
    logic [SW-1:0]     r_empty_slot;
    logic [LW-1:0]     r_k;
    logic [LW-1:0]     r_need;
    logic [DIR_ENTRIES-1:0] r_dvalid;
    logic [63:0]       r_dkey [DIR_ENTRIES];
    logic [LW-1:0]     r_dlen [DIR_ENTRIES];
    logic              r_rsp_valid;
    t_rsp              r_rsp;
    logic              r_rd_pend;

    logic              bm_we;
    logic [BW-1:0]     bm_waddr;
    logic              bm_wdata;
    logic [BW-1:0]     bm_raddr;
    logic              bm_rdata;
    logic              bl_we;
    logic [LAW-1:0]    bl_waddr;
    logic [BW-1:0]     bl_wdata;
    logic [LAW-1:0]    bl_raddr;
    logic [BW-1:0]     bl_rdata;
    logic [LAW-1:0]    slot_base;
    logic [8:0]        n_clamp;
    logic              rsp_load;

    iba_bitmap #(.DISK_BLOCKS(DISK_BLOCKS)) u_bitmap (
        .i_clk(i_clk), .i_we(bm_we), .i_waddr(bm_waddr), .i_wdata(bm_wdata),
        .i_raddr(bm_raddr), .o_rdata(bm_rdata)
    );

    iba_blklist #(.DEPTH(DIR_ENTRIES * LD), .AW(LAW), .DW(BW)) u_blklist (
        .i_clk(i_clk), .i_we(bl_we), .i_waddr(bl_waddr), .i_wdata(bl_wdata),
        .i_raddr(bl_raddr), .o_rdata(bl_rdata)
    );

    // clamp the register to 1..DISK_BLOCKS
    always_comb begin
        if (r_biu == 9'd0) begin
            n_clamp = 9'd1;
        end else if (32'(r_biu) > DISK_BLOCKS) begin
            n_clamp = 9'(DISK_BLOCKS);
        end else begin
            n_clamp = r_biu;
        end
    end

    assign slot_base = LAW'(32'(r_slot) * 32'(LD));

    // load the result register when it is empty or being drained
    assign rsp_load = !i_cfg_we && (r_state == S_OUT || r_state == S_RESP) &&
                      (!r_rsp_valid || i_rsp_ready);

    // memory port control
    always_comb begin
        bm_we    = 1'b0;
        bm_waddr = r_ptr;
        bm_wdata = 1'b1;
        bm_raddr = r_ptr;
        bl_we    = 1'b0;
        bl_waddr = slot_base + LAW'(r_k);
        bl_wdata = r_ptr;
        bl_raddr = slot_base + LAW'(r_k);
        unique case (r_state)
            S_CLEAR: begin
                bm_we = 1'b1;
            end
            S_SCAN: begin
                bm_we    = r_rd_pend && bm_rdata;
                bm_wdata = 1'b0;
                bm_waddr = r_ptr - BW'(1);
                bl_we    = r_rd_pend && bm_rdata;
                bl_wdata = r_ptr - BW'(1);
            end
            S_DEL_WR: begin
                bm_we    = 1'b1;
                bm_waddr = bl_rdata;
            end
            default: begin
            end
        endcase
    end

    // result valid: set on load, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (rsp_load) begin
            r_rsp_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    // sequencer, directory registers and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_ptr       <= '0;
            r_ptr_end   <= 1'b0;
            r_biu       <= 9'(DISK_BLOCKS);
            r_dvalid    <= '0;
            r_rd_pend   <= 1'b0;
            r_free      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_biu    <= i_cfg_wdata;
                r_state  <= S_CLEAR;
                r_ptr    <= '0;
                r_dvalid <= '0;
            end else begin
                unique case (r_state)
                    S_CLEAR: begin
                        r_ptr <= r_ptr + BW'(1);
                        if (r_ptr == BW'(DISK_BLOCKS - 1)) begin
                            r_free  <= n_clamp;
                            r_n     <= CW'(n_clamp);
                            r_state <= S_IDLE;
                        end
                    end
                    S_IDLE: begin
                        if (i_req_valid && !r_rsp_valid) begin
                            r_req   <= i_req;
                            r_slot  <= '0;
                            r_hit   <= 1'b0;
                            r_empty <= 1'b0;
                            r_state <= S_FIND;
                        end
                    end
                    S_FIND: begin
                        if (r_dvalid[r_slot] && r_dkey[r_slot] == r_req.file_key && !r_hit) begin
                            r_hit      <= 1'b1;
                            r_hit_slot <= r_slot;
                        end
                        if (!r_dvalid[r_slot] && !r_empty) begin
                            r_empty      <= 1'b1;
                            r_empty_slot <= r_slot;
                        end
                        if (32'(r_slot) == DIR_ENTRIES - 1) begin
                            r_state <= S_CHECK;
                        end else begin
                            r_slot <= r_slot + SW'(1);
                        end
                    end
                    S_CHECK: begin
                        r_k       <= '0;
                        r_ptr     <= '0;
                        r_ptr_end <= 1'b0;
                        r_rd_pend <= 1'b0;
                        r_cnt     <= '0;
                        r_rsp.block_number <= '0;
                        r_rsp.block_role   <= 1'b0;
                        r_rsp.last         <= 1'b1;
                        r_rsp.free_blocks  <= r_free;
                        if (r_req.opcode == OP_DELETE) begin
                            if (!r_hit) begin
                                r_rsp.status <= ST_NOTFOUND;
                                r_state      <= S_RESP;
                            end else begin
                                r_rsp.status <= ST_OK;
                                r_slot   <= r_hit_slot;
                                r_need   <= r_dlen[r_hit_slot] + LW'(1);
                                r_dvalid[r_hit_slot] <= 1'b0;
                                r_state  <= S_DEL_RD;
                            end
                        end else if (r_hit) begin
                            r_rsp.status <= ST_DUP;
                            r_state      <= S_RESP;
                        end else if (r_req.block_count == 5'd0 ||
                                     32'(r_req.block_count) > MAX_DATA_BLOCKS) begin
                            r_rsp.status <= ST_BADCNT;
                            r_state      <= S_RESP;
                        end else if (10'(r_req.block_count) + 10'd1 > 10'(r_free)) begin
                            r_rsp.status <= ST_FEW;
                            r_state      <= S_RESP;
                        end else if (!r_empty) begin
                            r_rsp.status <= ST_FULL;
                            r_state      <= S_RESP;
                        end else begin
                            r_rsp.status <= ST_OK;
                            r_slot   <= r_empty_slot;
                            r_need   <= LW'(r_req.block_count) + LW'(1);
                            r_dvalid[r_empty_slot] <= 1'b1;
                            r_dkey[r_empty_slot]   <= r_req.file_key;
                            r_dlen[r_empty_slot]   <= LW'(r_req.block_count);
                            r_free   <= r_free - 9'(r_req.block_count) - 9'd1;
                            r_state  <= S_SCAN;
                        end
                    end
                    // read one bit per cycle except on a claim; claim the previous address if free
                    S_SCAN: begin
                        if (r_rd_pend && bm_rdata) begin
                            if (r_k + LW'(1) == r_need) begin
                                r_k     <= '0;
                                r_state <= S_RD;
                            end else begin
                                r_k <= r_k + LW'(1);
                            end
                            r_rd_pend <= 1'b0;
                        end else begin
                            r_rd_pend <= 1'b1;
                            r_ptr     <= r_ptr + BW'(1);
                        end
                    end
                    S_RD: begin
                        r_state <= S_OUT;
                    end
                    S_OUT: begin
                        if (rsp_load) begin
                            r_rsp.status       <= ST_OK;
                            r_rsp.block_number <= 8'(bl_rdata);
                            r_rsp.block_role   <= (r_k != '0);
                            r_rsp.last         <= (r_k + LW'(1) == r_need);
                            r_rsp.free_blocks  <= r_free;
                            if (r_k + LW'(1) == r_need) begin
                                r_state <= S_IDLE;
                            end else begin
                                r_k     <= r_k + LW'(1);
                                r_state <= S_RD;
                            end
                        end
                    end
                    S_DEL_RD: begin
                        r_state <= S_DEL_WR;
                    end
                    S_DEL_WR: begin
                        if (r_k + LW'(1) == r_need) begin
                            r_ptr     <= '0;
                            r_cnt     <= '0;
                            r_rd_pend <= 1'b0;
                            r_ptr_end <= 1'b0;
                            r_state   <= S_CNT;
                        end else begin
                            r_k     <= r_k + LW'(1);
                            r_state <= S_DEL_RD;
                        end
                    end
                    // count free bits over the managed blocks
                    S_CNT: begin
                        if (r_rd_pend) begin
                            r_cnt <= r_cnt + 9'(bm_rdata);
                        end
                        if (r_ptr_end) begin
                            r_rd_pend <= 1'b0;
                            if (!r_rd_pend) begin
                                r_free            <= r_cnt;
                                r_rsp.free_blocks <= r_cnt;
                                r_state           <= S_RESP;
                            end
                        end else begin
                            r_rd_pend <= 1'b1;
                            if (CW'(r_ptr) + CW'(1) == r_n) begin
                                r_ptr_end <= 1'b1;
                            end else begin
                                r_ptr <= r_ptr + BW'(1);
                            end
                        end
                    end
                    S_RESP: begin
                        if (rsp_load) begin
                            r_state <= S_IDLE;
                        end
                    end
                    default: begin
                        r_state <= S_IDLE;
                    end
                endcase
            end
        end
    end

    assign o_req_ready = (r_state == S_IDLE) && !r_rsp_valid && !i_cfg_we;
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    // free count in idle never exceeds the disk size (DISK_BLOCKS)
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> r_free <= 9'(DISK_BLOCKS))
        else $error("free count above disk size");

    // a held result stays unchanged
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !i_rsp_ready && !i_cfg_we |=> o_rsp_valid && $stable(o_rsp))
        else $error("result changed while stalled");

    // no request taken during the clearing pass
    a_clear_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLEAR |-> !o_req_ready)
        else $error("request accepted during clear");

endmodule
